@@ rtl/core/fcfl_pkg.sv @@
package fcfl_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 17;
    localparam int SIZE8_W    = 14;
    localparam int OFF_W      = 26;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // null link: one past the last chunk
    localparam logic [LINK_W-1:0]  END_MARK   = LINK_W'(MAX_CHUNKS);
    localparam logic [CNT_W-1:0]   COUNT_MAX  = CNT_W'(MAX_CHUNKS);
    localparam logic [SIZE_W-1:0]  SIZE_SAT   = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0]  SIZE_MIN   = SIZE_W'(8);
    localparam logic [SIZE_W-1:0]  SIZE_RND   = SIZE_W'(7);
    localparam logic [SIZE8_W-1:0] SIZE8_SAT  = SIZE8_W'(8192);
    localparam logic [SIZE8_W-1:0] SIZE8_MIN  = SIZE8_W'(1);
    localparam logic [SIZE_W-1:0]  SIZE_RST   = SIZE_W'(8);

    typedef enum logic [0:0] {
        REG_CHUNK_SIZE  = 1'b0,
        REG_CHUNK_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STAT_ALLOC   = 2'd0,
        STAT_EXHAUST = 2'd1,
        STAT_FREED   = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic restart;
        logic build;
        logic accept;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic build_done;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/fcfl_if.sv @@
interface fcfl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [fcfl_pkg::IDX_W-1:0]  free_index;
    logic                        free_null;

    modport source (output valid, output req_type, output free_index, output free_null,
                    input ready);
    modport sink   (input valid, input req_type, input free_index, input free_null,
                    output ready);
endinterface

interface fcfl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fcfl_pkg::IDX_W-1:0]  chunk_index;
    logic [fcfl_pkg::OFF_W-1:0]  byte_offset;

    modport source (output valid, output status, output chunk_index, output byte_offset,
                    input ready);
    modport sink   (input valid, input status, input chunk_index, input byte_offset,
                    output ready);
endinterface

@@ rtl/core/fcfl_regs.sv @@
module fcfl_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcfl_pkg::PADDR_W-1:0]    paddr,
    input  logic [fcfl_pkg::PDATA_W-1:0]    pwdata,
    output logic [fcfl_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output logic                            rebuild,
    output logic [fcfl_pkg::SIZE8_W-1:0]    eff_size8,
    output logic [fcfl_pkg::CNT_W-1:0]      eff_count
);

    logic [fcfl_pkg::SIZE_W-1:0]  chunk_size_reg;
    logic [fcfl_pkg::SIZE_W-1:0]  chunk_size_next;
    logic [fcfl_pkg::CNT_W-1:0]   chunk_count_reg;
    logic [fcfl_pkg::CNT_W-1:0]   chunk_count_next;
    logic [fcfl_pkg::SIZE8_W-1:0] size8_reg;
    logic [fcfl_pkg::SIZE8_W-1:0] size8_next;
    logic [fcfl_pkg::CNT_W-1:0]   ecount_reg;
    logic [fcfl_pkg::CNT_W-1:0]   ecount_next;
    logic                         wr_en;
    fcfl_pkg::reg_idx_t           reg_idx;
    logic [fcfl_pkg::SIZE_W-1:0]  wsize;
    logic [fcfl_pkg::SIZE_W-1:0]  wsize_rnd;
    logic [fcfl_pkg::CNT_W-1:0]   wcount;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = fcfl_pkg::reg_idx_t'(paddr[2]);
    assign wsize     = pwdata[fcfl_pkg::SIZE_W-1:0];
    assign wsize_rnd = wsize + fcfl_pkg::SIZE_RND;
    assign wcount    = pwdata[fcfl_pkg::CNT_W-1:0];

    always_comb
    begin
        chunk_size_next  = chunk_size_reg;
        chunk_count_next = chunk_count_reg;
        size8_next       = size8_reg;
        ecount_next      = ecount_reg;
        if (wr_en)
        begin
            case (reg_idx)
                fcfl_pkg::REG_CHUNK_SIZE:
                begin
                    chunk_size_next = wsize;
                    // saturate, raise to the minimum, round up to 8 bytes (kept in units of 8)
                    if (wsize > fcfl_pkg::SIZE_SAT)
                        size8_next = fcfl_pkg::SIZE8_SAT;
                    else if (wsize < fcfl_pkg::SIZE_MIN)
                        size8_next = fcfl_pkg::SIZE8_MIN;
                    else
                        size8_next = wsize_rnd[fcfl_pkg::SIZE_W-1:3];
                end
                fcfl_pkg::REG_CHUNK_COUNT:
                begin
                    chunk_count_next = wcount;
                    ecount_next = (wcount > fcfl_pkg::COUNT_MAX) ? fcfl_pkg::COUNT_MAX : wcount;
                end
                default:
                begin
                    chunk_size_next = chunk_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg  <= fcfl_pkg::SIZE_RST;
            chunk_count_reg <= fcfl_pkg::COUNT_MAX;
            size8_reg       <= fcfl_pkg::SIZE8_MIN;
            ecount_reg      <= fcfl_pkg::COUNT_MAX;
        end
        else
        begin
            chunk_size_reg  <= chunk_size_next;
            chunk_count_reg <= chunk_count_next;
            size8_reg       <= size8_next;
            ecount_reg      <= ecount_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            fcfl_pkg::REG_CHUNK_SIZE:  prdata = fcfl_pkg::PDATA_W'(chunk_size_reg);
            fcfl_pkg::REG_CHUNK_COUNT: prdata = fcfl_pkg::PDATA_W'(chunk_count_reg);
            default:                   prdata = '0;
        endcase
    end

    assign rebuild   = wr_en;
    assign eff_size8 = size8_reg;
    assign eff_count = ecount_reg;

endmodule

@@ rtl/core/fcfl_ctrl.sv @@
module fcfl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rebuild,
    input  logic            in_valid,
    output logic            in_ready,
    input  fcfl_pkg::sts_t  sts,
    output fcfl_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_BUILD  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_BUILD:
            begin
                cmd.build = 1'b1;
                if (sts.build_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // commit the pop, then hand the result to the output stage once it is free
                cmd.finish = 1'b1;
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BUILD;
            end
        endcase
        if (rebuild)
        begin
            cmd.restart = 1'b1;
            state_next  = ST_BUILD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_BUILD;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/fcfl_dp.sv @@
module fcfl_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fcfl_pkg::cmd_t                  cmd,
    output fcfl_pkg::sts_t                  sts,
    input  logic [fcfl_pkg::SIZE8_W-1:0]    eff_size8,
    input  logic [fcfl_pkg::CNT_W-1:0]      eff_count,
    input  logic                            req_type,
    input  logic [fcfl_pkg::IDX_W-1:0]      free_index,
    input  logic                            free_null,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      out_status,
    output logic [fcfl_pkg::IDX_W-1:0]      out_index,
    output logic [fcfl_pkg::OFF_W-1:0]      out_offset
);

    localparam int PROD_W = fcfl_pkg::IDX_W + fcfl_pkg::SIZE8_W;

    logic [fcfl_pkg::LINK_W-1:0] mem [fcfl_pkg::MAX_CHUNKS];
    logic [fcfl_pkg::LINK_W-1:0] rdata_reg;

    logic [fcfl_pkg::LINK_W-1:0] head_reg;
    logic [fcfl_pkg::LINK_W-1:0] head_next;
    logic [fcfl_pkg::CNT_W-1:0]  bcnt_reg;
    logic [fcfl_pkg::CNT_W-1:0]  bcnt_next;
    logic                        pop_reg;
    logic                        pop_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    fcfl_pkg::status_t           res_status_reg;
    logic [fcfl_pkg::IDX_W-1:0]  res_index_reg;
    logic [fcfl_pkg::OFF_W-1:0]  res_offset_reg;
    fcfl_pkg::status_t           out_status_reg;
    logic [fcfl_pkg::IDX_W-1:0]  out_index_reg;
    logic [fcfl_pkg::OFF_W-1:0]  out_offset_reg;

    logic                        build_done;
    logic [fcfl_pkg::CNT_W-1:0]  bcnt_inc;
    logic [fcfl_pkg::LINK_W-1:0] build_link;
    logic                        is_alloc;
    logic                        head_empty;
    logic                        free_ok;
    logic                        pop_ok;
    logic [PROD_W-1:0]           prod;
    logic [PROD_W+2:0]           offset_full;
    logic                        mem_we;
    logic [fcfl_pkg::IDX_W-1:0]  mem_waddr;
    logic [fcfl_pkg::LINK_W-1:0] mem_wdata;

    assign build_done = (bcnt_reg >= eff_count);
    assign bcnt_inc   = bcnt_reg + 1'b1;
    assign build_link = (bcnt_inc < eff_count) ? fcfl_pkg::LINK_W'(bcnt_inc) : fcfl_pkg::END_MARK;

    assign is_alloc   = (fcfl_pkg::req_t'(req_type) == fcfl_pkg::REQ_ALLOC);
    assign head_empty = head_reg[fcfl_pkg::IDX_W];
    assign free_ok    = !is_alloc && !free_null &&
                        ({1'b0, free_index} < eff_count);
    assign pop_ok     = is_alloc && !head_empty;

    assign prod        = head_reg[fcfl_pkg::IDX_W-1:0] * eff_size8;
    assign offset_full = {prod, 3'b000};

    assign mem_we    = (cmd.build && !build_done) || (cmd.accept && free_ok);
    assign mem_waddr = cmd.build ? bcnt_reg[fcfl_pkg::IDX_W-1:0] : free_index;
    assign mem_wdata = cmd.build ? build_link : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.accept && pop_ok)
            rdata_reg <= mem[head_reg[fcfl_pkg::IDX_W-1:0]];
    end

    always_comb
    begin
        head_next = head_reg;
        bcnt_next = bcnt_reg;
        pop_next  = pop_reg;
        if (cmd.restart)
        begin
            bcnt_next = '0;
            pop_next  = 1'b0;
        end
        else if (cmd.build)
        begin
            head_next = (eff_count == '0) ? fcfl_pkg::END_MARK : '0;
            if (!build_done)
                bcnt_next = bcnt_inc;
        end
        else if (cmd.accept)
        begin
            pop_next = pop_ok;
            if (free_ok)
                head_next = {1'b0, free_index};
        end
        else if (cmd.finish)
        begin
            if (pop_reg)
                head_next = rdata_reg;
            if (cmd.load_out)
                pop_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            bcnt_reg      <= '0;
            pop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            bcnt_reg      <= bcnt_next;
            pop_reg       <= pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_index_reg  <= '0;
            res_offset_reg <= '0;
            if (is_alloc)
            begin
                if (head_empty)
                    res_status_reg <= fcfl_pkg::STAT_EXHAUST;
                else
                begin
                    res_status_reg <= fcfl_pkg::STAT_ALLOC;
                    res_index_reg  <= head_reg[fcfl_pkg::IDX_W-1:0];
                    res_offset_reg <= offset_full[fcfl_pkg::OFF_W-1:0];
                end
            end
            else if (free_ok)
                res_status_reg <= fcfl_pkg::STAT_FREED;
            else
                res_status_reg <= fcfl_pkg::STAT_IGNORED;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_offset_reg <= res_offset_reg;
        end
    end

    assign sts.build_done = build_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_offset = out_offset_reg;

endmodule

@@ rtl/core/fixed_chunk_free_list_allocator.sv @@
// Pool allocator over up to 1024 equal chunks, kept as a LIFO free list of next-links in a
// single-port-write, registered-read link memory. After reset, and after every register write,
// the block rebuilds the chain 0 -> 1 -> ... -> count-1 (count capped at 1024) with one link
// written per cycle; no request is taken meanwhile, while register writes are always taken and
// restart the rebuild. Every write to chunk_size or chunk_count discards all outstanding
// allocations. For each request, the transfer reads the head's next-link from the link memory
// and forms the result, and the finish state that follows commits the new head, since the next
// pop depends on that link. One result follows each request. A result waiting in the output
// register does not stall the next request; only a second finished result waits for the output
// to drain. Allocate returns the head chunk and its byte offset (index times chunk_size raised
// to 8 and rounded up to a multiple of 8, saturated at 65536), or exhausted when the list is
// empty. Free pushes the given index; a null free or an index at or above the chunk count is
// ignored. Double frees are not checked and are pushed like any other free.
module fixed_chunk_free_list_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port: chunk_size at 0x0, chunk_count at 0x4
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcfl_pkg::PADDR_W-1:0]    paddr,
    input  logic [fcfl_pkg::PDATA_W-1:0]    pwdata,
    output logic [fcfl_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // request and result channels
    fcfl_req_if.sink                        req,
    fcfl_rsp_if.source                      rsp
);

    logic                         rebuild;
    logic [fcfl_pkg::SIZE8_W-1:0] eff_size8;
    logic [fcfl_pkg::CNT_W-1:0]   eff_count;
    fcfl_pkg::cmd_t               cmd;
    fcfl_pkg::sts_t               sts;
    logic                         in_ready;

    // register file; a completed write pulses rebuild
    fcfl_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .rebuild   (rebuild),
        .eff_size8 (eff_size8),
        .eff_count (eff_count)
    );

    // sequencer: rebuild sweep, request transfer, result hand-off
    fcfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rebuild  (rebuild),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // link memory, head and build counter, offset multiplier, result and output registers
    fcfl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .eff_size8  (eff_size8),
        .eff_count  (eff_count),
        .req_type   (req.req_type),
        .free_index (req.free_index),
        .free_null  (req.free_null),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_index  (rsp.chunk_index),
        .out_offset (rsp.byte_offset)
    );

endmodule

@@ test/fixed_chunk_free_list_allocator_tb.sv @@
module fixed_chunk_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits: the cycle cap covers the worst case of long gaps on both sides for every
    // item plus a full rebuild after reset and after every register write.
    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 1000000;

    typedef enum logic [1:0] {
        STIM_REQ,
        STIM_CFG,
        STIM_PAUSE
    } stim_kind_t;

    typedef enum logic [3:0] {
        DRV_RUN     = 4'b0001,
        DRV_QUIESCE = 4'b0010,
        DRV_SETUP   = 4'b0100,
        DRV_ACCESS  = 4'b1000
    } drv_state_t;

    typedef struct {
        stim_kind_t                           kind;
        fcfl_pkg::req_t                       op;
        logic [fcfl_pkg::IDX_W-1:0]           index;
        logic                                 is_null;
        fcfl_pkg::reg_idx_t                   regsel;
        logic [fcfl_pkg::PDATA_W-1:0]         value;
    } stim_t;

    typedef struct {
        fcfl_pkg::status_t                    status;
        logic [fcfl_pkg::IDX_W-1:0]           chunk_index;
        logic [fcfl_pkg::OFF_W-1:0]           byte_offset;
    } reply_t;

    // Clock, reset and the block's pins. Every input starts at a known value.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [fcfl_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [fcfl_pkg::PDATA_W-1:0]  pwdata  = '0;
    logic [fcfl_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    logic                          req_valid   = 1'b0;
    fcfl_pkg::req_t                req_op      = fcfl_pkg::REQ_ALLOC;
    logic [fcfl_pkg::IDX_W-1:0]    req_index   = '0;
    logic                          req_is_null = 1'b0;
    logic                          rsp_rdy     = 1'b0;

    fcfl_req_if req_ch ();
    fcfl_rsp_if rsp_ch ();

    assign req_ch.valid      = req_valid;
    assign req_ch.req_type   = req_op;
    assign req_ch.free_index = req_index;
    assign req_ch.free_null  = req_is_null;
    assign rsp_ch.ready      = rsp_rdy;

    fixed_chunk_free_list_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #2 clk = ~clk;

    // Pending stimulus, filled before reset is released and drained by the driver.
    stim_t stim_q [$];

    // Stimulus-side view of the pool, kept only to build well-formed sequences: which chunks
    // sit on the free list (head first) and which ones are handed out.
    int free_stack [$];
    int held [$];
    int gen_count_reg = int'(fcfl_pkg::COUNT_MAX);
    int gen_chunks    = fcfl_pkg::MAX_CHUNKS;
    int req_items     = 0;

    // Predicted pool state and the replies it has produced but not yet seen.
    logic [fcfl_pkg::SIZE_W-1:0]  pool_size_reg;
    logic [fcfl_pkg::CNT_W-1:0]   pool_count_reg;
    logic [fcfl_pkg::LINK_W-1:0]  pool_link [fcfl_pkg::MAX_CHUNKS];
    logic [fcfl_pkg::LINK_W-1:0]  pool_head;
    reply_t                       predicted_replies [$];

    int          outstanding = 0;
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          took_req;
    bit          took_rsp;
    bit          stim_done   = 1'b0;
    drv_state_t  drv_state   = DRV_RUN;
    int          gap_left    = 0;
    int          quiet_left  = 0;
    int          stall_left  = 0;
    int          rsp_hold;
    int          calm_timer  = 0;
    bit          req_calm    = 1'b0;
    bit          rsp_calm    = 1'b0;

    function automatic logic [fcfl_pkg::PADDR_W-1:0] reg_addr(fcfl_pkg::reg_idx_t r);
        return fcfl_pkg::PADDR_W'({r, 2'b00});
    endfunction

    // Idle length: mostly none, some short, a few long; none at all in a calm stretch.
    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // Pool predictor
    // ------------------------------------------------------------------

    // Chunks in use: the count register saturates at the pool capacity.
    function automatic int pool_chunks();
        int c;
        c = int'(pool_count_reg);
        return (c > fcfl_pkg::MAX_CHUNKS) ? fcfl_pkg::MAX_CHUNKS : c;
    endfunction

    // Chunk stride: clamp to [8, 65536] bytes, then round up to a multiple of 8.
    function automatic int pool_chunk_bytes();
        int s;
        s = int'(pool_size_reg);
        if (s > int'(fcfl_pkg::SIZE_SAT))
            s = int'(fcfl_pkg::SIZE_SAT);
        if (s < int'(fcfl_pkg::SIZE_MIN))
            s = int'(fcfl_pkg::SIZE_MIN);
        return (s + 7) & ~7;
    endfunction

    // Chain 0 -> 1 -> ... -> n-1 with chunk 0 on top; an empty pool has the end mark on top.
    function automatic void pool_rebuild();
        int n;
        n = pool_chunks();
        for (int i = 0; i < fcfl_pkg::MAX_CHUNKS; i++)
            pool_link[i] = (i + 1 < n) ? fcfl_pkg::LINK_W'(i + 1) : fcfl_pkg::END_MARK;
        pool_head = (n == 0) ? fcfl_pkg::END_MARK : '0;
    endfunction

    // One request against the free list: pop on allocate, push on free.
    function automatic reply_t pool_step(fcfl_pkg::req_t op, logic [fcfl_pkg::IDX_W-1:0] idx,
                                         logic is_null);
        reply_t r;
        int     h;
        r.status      = fcfl_pkg::STAT_ALLOC;
        r.chunk_index = '0;
        r.byte_offset = '0;
        if (op == fcfl_pkg::REQ_ALLOC)
        begin
            if (pool_head >= fcfl_pkg::END_MARK)
            begin
                r.status = fcfl_pkg::STAT_EXHAUST;
            end
            else
            begin
                h             = int'(pool_head);
                pool_head     = pool_link[h];
                r.chunk_index = fcfl_pkg::IDX_W'(h);
                r.byte_offset = fcfl_pkg::OFF_W'(h * pool_chunk_bytes());
            end
        end
        else if (is_null || int'(idx) >= pool_chunks())
        begin
            // null pointer or a chunk beyond the pool: nothing changes
            r.status = fcfl_pkg::STAT_IGNORED;
        end
        else
        begin
            // no double-free check: the index goes on top regardless
            pool_link[idx] = pool_head;
            pool_head      = {1'b0, idx};
            r.status       = fcfl_pkg::STAT_FREED;
        end
        return r;
    endfunction

    task automatic check_reply(reply_t got);
        reply_t want;
        if (predicted_replies.size() == 0)
        begin
            $error("reply with no request pending: status %0d chunk_index %0d byte_offset %0d",
                   got.status, got.chunk_index, got.byte_offset);
            err_count++;
        end
        else
        begin
            want = predicted_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                err_count++;
            end
            if (got.chunk_index !== want.chunk_index)
            begin
                $error("chunk_index: expected %0d, got %0d", want.chunk_index, got.chunk_index);
                err_count++;
            end
            if (got.byte_offset !== want.byte_offset)
            begin
                $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
                err_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void add_req(fcfl_pkg::req_t op, int idx, bit is_null);
        stim_t s;
        s.kind    = STIM_REQ;
        s.op      = op;
        s.index   = fcfl_pkg::IDX_W'(idx);
        s.is_null = is_null;
        s.regsel  = fcfl_pkg::REG_CHUNK_SIZE;
        s.value   = '0;
        stim_q.push_back(s);
        req_items++;
    endfunction

    // A register write rebuilds the pool, so restart the stimulus-side view as well.
    function automatic void add_cfg(fcfl_pkg::reg_idx_t r, int v);
        stim_t s;
        s.kind    = STIM_CFG;
        s.op      = fcfl_pkg::REQ_ALLOC;
        s.index   = '0;
        s.is_null = 1'b0;
        s.regsel  = r;
        s.value   = fcfl_pkg::PDATA_W'(v);
        stim_q.push_back(s);
        if (r == fcfl_pkg::REG_CHUNK_COUNT)
            gen_count_reg = v;
        gen_chunks = (gen_count_reg > fcfl_pkg::MAX_CHUNKS) ? fcfl_pkg::MAX_CHUNKS
                                                             : gen_count_reg;
        free_stack.delete();
        held.delete();
        for (int i = 0; i < gen_chunks; i++)
            free_stack.push_back(i);
    endfunction

    function automatic void add_pause();
        stim_t s;
        s.kind    = STIM_PAUSE;
        s.op      = fcfl_pkg::REQ_ALLOC;
        s.index   = '0;
        s.is_null = 1'b0;
        s.regsel  = fcfl_pkg::REG_CHUNK_SIZE;
        s.value   = '0;
        stim_q.push_back(s);
    endfunction

    // Allocate with random don't-care fields; track the chunk that comes off the top.
    function automatic void take_chunk();
        add_req(fcfl_pkg::REQ_ALLOC, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
        if (free_stack.size() != 0)
            held.push_back(free_stack.pop_front());
    endfunction

    // Return one of the handed-out chunks, picked at random.
    function automatic void give_back();
        int k;
        int c;
        k = $urandom_range(0, held.size() - 1);
        c = held[k];
        held.delete(k);
        free_stack.push_front(c);
        add_req(fcfl_pkg::REQ_FREE, c, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Calm stretches: windows in which one side or the other never idles
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (calm_timer == 0)
        begin
            calm_timer <= $urandom_range(50, 400);
            req_calm   <= ($urandom_range(0, 3) == 0);
            rsp_calm   <= ($urandom_range(0, 3) == 0);
        end
        else
        begin
            calm_timer <= calm_timer - 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver: request channel and configuration port
    // ------------------------------------------------------------------
    // Hold a request until its transfer, then idle for the chosen gap. A register write or a
    // pause marker first lets every outstanding reply come back and the block settle, then
    // runs the setup and access phases on the configuration port (or simply resumes).
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_op      <= fcfl_pkg::REQ_ALLOC;
            req_index   <= '0;
            req_is_null <= 1'b0;
            psel        <= 1'b0;
            penable     <= 1'b0;
            pwrite      <= 1'b0;
            paddr       <= '0;
            pwdata      <= '0;
            drv_state   <= DRV_RUN;
            gap_left    <= 0;
            quiet_left  <= 0;
            stim_done   <= 1'b0;
        end
        else
        begin
            case (drv_state)
                DRV_RUN:
                begin
                    if (req_valid && !req_ch.ready)
                    begin
                        // hold: the block has not taken the request yet
                    end
                    else if (gap_left != 0)
                    begin
                        req_valid <= 1'b0;
                        gap_left  <= gap_left - 1;
                    end
                    else if (stim_q.size() == 0)
                    begin
                        req_valid <= 1'b0;
                        stim_done <= 1'b1;
                    end
                    else if (stim_q[0].kind == STIM_REQ)
                    begin
                        req_valid   <= 1'b1;
                        req_op      <= stim_q[0].op;
                        req_index   <= stim_q[0].index;
                        req_is_null <= stim_q[0].is_null;
                        gap_left    <= idle_len(req_calm);
                        void'(stim_q.pop_front());
                    end
                    else
                    begin
                        req_valid  <= 1'b0;
                        quiet_left <= QUIET_CYCLES;
                        drv_state  <= DRV_QUIESCE;
                    end
                end
                DRV_QUIESCE:
                begin
                    // restart the settle count whenever a reply is still owed
                    if (outstanding != 0)
                    begin
                        quiet_left <= QUIET_CYCLES;
                    end
                    else if (quiet_left != 0)
                    begin
                        quiet_left <= quiet_left - 1;
                    end
                    else if (stim_q[0].kind == STIM_CFG)
                    begin
                        psel      <= 1'b1;
                        penable   <= 1'b0;
                        pwrite    <= 1'b1;
                        paddr     <= reg_addr(stim_q[0].regsel);
                        pwdata    <= stim_q[0].value;
                        drv_state <= DRV_SETUP;
                        void'(stim_q.pop_front());
                    end
                    else
                    begin
                        drv_state <= DRV_RUN;
                        void'(stim_q.pop_front());
                    end
                end
                DRV_SETUP:
                begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS:
                begin
                    if (pready)
                    begin
                        psel      <= 1'b0;
                        penable   <= 1'b0;
                        pwrite    <= 1'b0;
                        drv_state <= DRV_RUN;
                    end
                end
                default:
                begin
                    drv_state <= DRV_RUN;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result-side back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_rdy    <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_rdy    <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_hold    = idle_len(rsp_calm);
            rsp_rdy    <= (rsp_hold == 0);
            stall_left <= (rsp_hold == 0) ? 0 : rsp_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each request transfer, compare on each reply transfer
    // ------------------------------------------------------------------
    // Push the prediction before popping, so a reply is always matched with the oldest
    // request still owed one. Register writes land only while idle, so their order
    // against the channels does not matter.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pool_size_reg  = fcfl_pkg::SIZE_RST;
            pool_count_reg = fcfl_pkg::COUNT_MAX;
            pool_rebuild();
            predicted_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            took_req = req_ch.valid && req_ch.ready;
            took_rsp = rsp_ch.valid && rsp_ch.ready;
            if (took_req)
                predicted_replies.push_back(pool_step(fcfl_pkg::req_t'(req_ch.req_type),
                                                      req_ch.free_index, req_ch.free_null));
            if (took_rsp)
                check_reply('{fcfl_pkg::status_t'(rsp_ch.status), rsp_ch.chunk_index,
                              rsp_ch.byte_offset});
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == reg_addr(fcfl_pkg::REG_CHUNK_SIZE))
                begin
                    pool_size_reg = pwdata[fcfl_pkg::SIZE_W-1:0];
                    pool_rebuild();
                end
                else if (paddr == reg_addr(fcfl_pkg::REG_CHUNK_COUNT))
                begin
                    pool_count_reg = pwdata[fcfl_pkg::CNT_W-1:0];
                    pool_rebuild();
                end
            end
            outstanding <= outstanding + int'(took_req) - int'(took_rsp);
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $error("no progress after %0d cycles, %0d replies still owed",
                   LIMIT_CYCLES, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int size_marks [12];
        int count_marks [6];
        int r;
        int v;
        int phase_len;
        int bias;
        int pause_at;

        size_marks  = '{0, 1, 7, 8, 9, 15, 16, 17, 65535, 65536, 65537, 131071};
        count_marks = '{0, 1, 2, 1023, 1024, 2047};

        // Directed part, starting from the reset setting: 8-byte chunks, 1024 of them.
        for (int i = 0; i < fcfl_pkg::MAX_CHUNKS; i++)
            free_stack.push_back(i);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);     // chunk 0 at offset 0
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);     // chunk 1 at offset 8
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);     // chunk 2 at offset 16
        add_req(fcfl_pkg::REQ_FREE, 1, 1'b0);      // push chunk 1
        add_req(fcfl_pkg::REQ_ALLOC, 1023, 1'b1);  // free fields set on an allocate: ignored
        add_req(fcfl_pkg::REQ_FREE, 2, 1'b1);      // null free: ignored
        add_req(fcfl_pkg::REQ_FREE, 2, 1'b0);
        add_pause();                               // let every reply come back mid-stream

        // Size below the minimum and an empty pool: every allocate is exhausted and any
        // free index is out of range.
        add_cfg(fcfl_pkg::REG_CHUNK_SIZE, 0);
        add_cfg(fcfl_pkg::REG_CHUNK_COUNT, 0);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);
        add_req(fcfl_pkg::REQ_FREE, 0, 1'b0);

        // Both registers beyond their saturation points: 65536-byte chunks, 1024 of them.
        add_cfg(fcfl_pkg::REG_CHUNK_SIZE, 131071);
        add_cfg(fcfl_pkg::REG_CHUNK_COUNT, 2047);
        add_req(fcfl_pkg::REQ_FREE, 1023, 1'b0);   // never handed out, pushed anyway
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);     // top chunk 1023: largest byte offset
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);
        add_req(fcfl_pkg::REQ_FREE, 0, 1'b0);
        add_req(fcfl_pkg::REQ_FREE, 0, 1'b0);      // double free: chunk 0 now links to itself
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);

        // Single chunk, size rounded up to 16.
        add_cfg(fcfl_pkg::REG_CHUNK_SIZE, 9);
        add_cfg(fcfl_pkg::REG_CHUNK_COUNT, 1);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);     // pool drained: exhausted
        add_req(fcfl_pkg::REQ_FREE, 1, 1'b0);      // index at the count: ignored
        add_req(fcfl_pkg::REQ_FREE, 0, 1'b0);
        add_req(fcfl_pkg::REQ_ALLOC, 0, 1'b0);

        // Random phases. Each opens with one or both registers rewritten; most traffic is
        // well-formed allocate/free traffic, the rest null frees, out-of-range frees and, at
        // the end of some phases, frees of chunks that are not handed out.
        while (req_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 2);
            if (r != 1)
            begin
                case ($urandom_range(0, 2))
                    0:       v = size_marks[$urandom_range(0, 11)];
                    1:       v = $urandom_range(0, 300);
                    default: v = $urandom_range(0, 131071);
                endcase
                add_cfg(fcfl_pkg::REG_CHUNK_SIZE, v);
            end
            if (r != 0)
            begin
                case ($urandom_range(0, 4))
                    0:       v = count_marks[$urandom_range(0, 5)];
                    1:       v = $urandom_range(0, 3);
                    2:       v = $urandom_range(4, 40);
                    3:       v = $urandom_range(41, 1023);
                    default: v = $urandom_range(1025, 2047);
                endcase
                add_cfg(fcfl_pkg::REG_CHUNK_COUNT, v);
            end

            phase_len = $urandom_range(60, 220);
            bias      = $urandom_range(25, 80);
            pause_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(10, phase_len - 10) : -1;
            for (int k = 0; k < phase_len; k++)
            begin
                if (k == pause_at)
                    add_pause();
                r = $urandom_range(0, 99);
                if (r < 5)
                    add_req(fcfl_pkg::REQ_FREE, $urandom_range(0, 1023), 1'b1);
                else if (r < 10 && gen_chunks < fcfl_pkg::MAX_CHUNKS)
                    add_req(fcfl_pkg::REQ_FREE, $urandom_range(gen_chunks, 1023), 1'b0);
                else if (held.size() == 0)
                    take_chunk();
                else if (free_stack.size() != 0 && $urandom_range(0, 99) < bias)
                    take_chunk();
                else if (free_stack.size() == 0 && $urandom_range(0, 99) < 15)
                    take_chunk();                  // probe the exhausted pool
                else
                    give_back();
            end

            // Tangle the list with frees of chunks still on it, then pop through the damage.
            if (gen_chunks != 0 && $urandom_range(0, 1) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    add_req(fcfl_pkg::REQ_FREE, $urandom_range(0, gen_chunks - 1), 1'b0);
                repeat ($urandom_range(2, 8))
                    add_req(fcfl_pkg::REQ_ALLOC, $urandom_range(0, 1023),
                            1'($urandom_range(0, 1)));
            end
        end

        // Reset first; the block then spends its own rebuild before the first
        // transfer, which the driver simply waits out on ready.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_done);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predicted_replies.size() != 0)
        begin
            $error("%0d replies never arrived", predicted_replies.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
